### design/rstat_pkg.sv
`timescale 1ns / 1ps
package rstat_pkg;

  localparam int SAMPLE_W = 24;
  localparam int RESULT_W = 34;
  localparam int MODE_W   = 3;
  localparam int CNT_W    = 11;
  localparam int SUM_W    = 34;
  localparam int SQ_W     = 57;
  // Signed accumulator for count*squares - sum*sum.
  localparam int ACC_W    = 68;
  // Dividend and divisor widths of the shared restoring divider.
  localparam int DVD_W    = 67;
  localparam int DVS_W    = 21;
  // Radicand width of the bit-serial square root.
  localparam int ROOT_W   = 48;
  localparam int ITER_W   = 7;
  localparam int COUNT_SHIFT = 12;

  localparam int MA_STEPS   = CNT_W;
  localparam int MB_STEPS   = SUM_W;
  localparam int DIV_STEPS  = DVD_W;
  localparam int SQRT_STEPS = ROOT_W / 2;

  localparam logic [MODE_W-1:0] MODE_AVG   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MIN   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAX   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SUM   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STDEV = 3'd5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_MA,
    OP_STEP_MA,
    OP_LOAD_MB,
    OP_STEP_MB,
    OP_LOAD_DIV_VAR,
    OP_LOAD_DIV_AVG,
    OP_STEP_DIV,
    OP_LOAD_SQRT,
    OP_STEP_SQRT,
    OP_RESULT
  } rstat_op_e;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_QUO,
    SEL_MIN,
    SEL_MAX,
    SEL_SUM,
    SEL_COUNT,
    SEL_ROOT
  } rstat_sel_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       usable;
    logic                       last;
  } rstat_in_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic                       empty_res;
  } rstat_out_t;

  typedef struct packed {
    logic       take;
    rstat_op_e  op;
    rstat_sel_e sel;
  } rstat_cmd_t;

  typedef struct packed {
    logic empty;
    logic acc_neg;
  } rstat_stat_t;

endpackage

### design/rstat_dp.sv
`timescale 1ns / 1ps
module rstat_dp #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rstat_pkg::rstat_cmd_t  cmd_i,
  input  rstat_pkg::rstat_in_t   in_data_i,
  output rstat_pkg::rstat_stat_t stat_o,
  output rstat_pkg::rstat_out_t  out_data_o
);
  import rstat_pkg::*;

  logic [CNT_W-1:0]           count_q, count_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [SQ_W-1:0]            sq_q, sq_d;
  logic signed [SAMPLE_W-1:0] min_q, min_d;
  logic signed [SAMPLE_W-1:0] max_q, max_d;

  logic [SAMPLE_W-1:0]   smag;
  logic [2*SAMPLE_W-1:0] ssq;
  logic                  take_ok;
  logic                  first;

  logic signed [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0]        mcand_q;
  logic [SUM_W-1:0]        mplier_q;
  logic [SUM_W-1:0]        sum_mag;
  logic [2*CNT_W-1:0]      nsq;

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic             neg_q;
  logic [DVS_W:0]   div_shift;
  logic [DVS_W:0]   div_diff;
  logic             div_ge;

  logic [ROOT_W-1:0] x_q, root_q, bit_q;
  logic [ROOT_W-1:0] sq_trial;
  logic              sq_ge;

  logic signed [RESULT_W-1:0] quo_res;
  logic signed [RESULT_W-1:0] res_val;
  rstat_out_t                 out_q;

  // Accumulates one usable sample per cycle, up to MAX_SAMPLES, on taken requests.
  assign smag    = in_data_i.sample[SAMPLE_W-1] ? $unsigned(-in_data_i.sample)
                                                : $unsigned(in_data_i.sample);
  assign ssq     = smag * smag;
  assign first   = (count_q == '0);
  assign take_ok = cmd_i.take && in_data_i.usable && (count_q < CNT_W'(MAX_SAMPLES));

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    min_d   = min_q;
    max_d   = max_q;
    if (cmd_i.op == OP_RESULT) begin
      count_d = '0;
      sum_d   = '0;
      sq_d    = '0;
      min_d   = '0;
      max_d   = '0;
    end else if (take_ok) begin
      count_d = count_q + CNT_W'(1);
      sum_d   = sum_q + SUM_W'(in_data_i.sample);
      sq_d    = sq_q + SQ_W'(ssq);
      if (first || in_data_i.sample < min_q) begin
        min_d = in_data_i.sample;
      end
      if (first || in_data_i.sample > max_q) begin
        max_d = in_data_i.sample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      min_q   <= '0;
      max_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  // End-of-run engine: shift-add multiplier, restoring divider, bit-serial root.
  assign sum_mag   = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
  assign nsq       = count_q * count_q;
  assign div_shift = {rem_q, quo_q[DVD_W-1]};
  assign div_ge    = (div_shift >= {1'b0, dvs_q});
  assign div_diff  = div_shift - {1'b0, dvs_q};
  assign sq_trial  = root_q + bit_q;
  assign sq_ge     = (x_q >= sq_trial);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD_MA: begin
        acc_q    <= '0;
        mcand_q  <= ACC_W'(sq_q);
        mplier_q <= SUM_W'(count_q);
      end
      OP_STEP_MA: begin
        if (mplier_q[0]) begin
          acc_q <= acc_q + $signed(mcand_q);
        end
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      OP_LOAD_MB: begin
        mcand_q  <= ACC_W'(sum_mag);
        mplier_q <= sum_mag;
      end
      OP_STEP_MB: begin
        if (mplier_q[0]) begin
          acc_q <= acc_q - $signed(mcand_q);
        end
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      OP_LOAD_DIV_VAR: begin
        quo_q <= acc_q[DVD_W-1:0];
        rem_q <= '0;
        dvs_q <= nsq[DVS_W-1:0];
      end
      OP_LOAD_DIV_AVG: begin
        quo_q <= DVD_W'(sum_mag);
        rem_q <= '0;
        dvs_q <= DVS_W'(count_q);
        neg_q <= sum_q[SUM_W-1];
      end
      OP_STEP_DIV: begin
        quo_q <= {quo_q[DVD_W-2:0], div_ge};
        rem_q <= div_ge ? div_diff[DVS_W-1:0] : div_shift[DVS_W-1:0];
      end
      OP_LOAD_SQRT: begin
        x_q    <= quo_q[ROOT_W-1:0];
        root_q <= '0;
        bit_q  <= ROOT_W'(1) << (ROOT_W - 2);
      end
      OP_STEP_SQRT: begin
        if (sq_ge) begin
          x_q    <= x_q - sq_trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: begin
      end
    endcase
  end

  // Result selection into the output register.
  assign quo_res = $signed(quo_q[RESULT_W-1:0]);

  always_comb begin
    case (cmd_i.sel)
      SEL_QUO:   res_val = neg_q ? -quo_res : quo_res;
      SEL_MIN:   res_val = RESULT_W'(min_q);
      SEL_MAX:   res_val = RESULT_W'(max_q);
      SEL_SUM:   res_val = RESULT_W'(sum_q);
      SEL_COUNT: res_val = $signed(RESULT_W'(count_q) << COUNT_SHIFT);
      SEL_ROOT:  res_val = $signed(root_q[RESULT_W-1:0]);
      default:   res_val = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESULT) begin
      out_q.result    <= res_val;
      out_q.empty_res <= first;
    end
  end

  assign out_data_o     = out_q;
  assign stat_o.empty   = first;
  assign stat_o.acc_neg = acc_q[ACC_W-1];

endmodule

### design/rstat_ctrl.sv
`timescale 1ns / 1ps
module rstat_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic                        cfg_we_i,
  input  logic [rstat_pkg::MODE_W-1:0] cfg_wdata_i,
  input  rstat_pkg::rstat_stat_t      stat_i,
  output rstat_pkg::rstat_cmd_t       cmd_o
);
  import rstat_pkg::*;

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_MUL_A = 3'd2;
  localparam logic [2:0] ST_MUL_B = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_SQRT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  rstat_sel_e        sel_q, sel_d;
  logic [MODE_W-1:0] mode_q;
  logic              out_valid_q, out_valid_d;
  logic              take;
  rstat_op_e         op;

  assign in_ready_o = (state_q == ST_ACC);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    op      = OP_NOP;
    case (state_q)
      ST_ACC: begin
        if (take && in_last_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        cnt_d   = '0;
        state_d = ST_DONE;
        if (stat_i.empty) begin
          sel_d = SEL_ZERO;
        end else begin
          case (mode_q)
            MODE_AVG: begin
              op      = OP_LOAD_DIV_AVG;
              state_d = ST_DIV;
            end
            MODE_MIN:   sel_d = SEL_MIN;
            MODE_MAX:   sel_d = SEL_MAX;
            MODE_SUM:   sel_d = SEL_SUM;
            MODE_COUNT: sel_d = SEL_COUNT;
            MODE_STDEV: begin
              op      = OP_LOAD_MA;
              state_d = ST_MUL_A;
            end
            default:    sel_d = SEL_ZERO;
          endcase
        end
      end
      ST_MUL_A: begin
        if (cnt_q == ITER_W'(MA_STEPS)) begin
          op      = OP_LOAD_MB;
          cnt_d   = '0;
          state_d = ST_MUL_B;
        end else begin
          op    = OP_STEP_MA;
          cnt_d = cnt_q + ITER_W'(1);
        end
      end
      ST_MUL_B: begin
        if (cnt_q == ITER_W'(MB_STEPS)) begin
          cnt_d   = '0;
          state_d = ST_CHECK;
        end else begin
          op    = OP_STEP_MB;
          cnt_d = cnt_q + ITER_W'(1);
        end
      end
      ST_CHECK: begin
        if (stat_i.acc_neg) begin
          sel_d   = SEL_ZERO;
          state_d = ST_DONE;
        end else begin
          op      = OP_LOAD_DIV_VAR;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == ITER_W'(DIV_STEPS)) begin
          cnt_d = '0;
          if (mode_q == MODE_AVG) begin
            sel_d   = SEL_QUO;
            state_d = ST_DONE;
          end else begin
            op      = OP_LOAD_SQRT;
            state_d = ST_SQRT;
          end
        end else begin
          op    = OP_STEP_DIV;
          cnt_d = cnt_q + ITER_W'(1);
        end
      end
      ST_SQRT: begin
        if (cnt_q == ITER_W'(SQRT_STEPS)) begin
          sel_d   = SEL_ROOT;
          state_d = ST_DONE;
        end else begin
          op    = OP_STEP_SQRT;
          cnt_d = cnt_q + ITER_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          op      = OP_RESULT;
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_comb begin
    if (op == OP_RESULT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      cnt_q       <= '0;
      sel_q       <= SEL_ZERO;
      mode_q      <= MODE_AVG;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  assign cmd_o.take = take;
  assign cmd_o.op   = op;
  assign cmd_o.sel  = sel_q;
  assign out_valid_o = out_valid_q;

endmodule

### design/rollup_statistics.sv
`timescale 1ns / 1ps
// Throughput: one sample request per cycle within a run; the request port closes from a last
// request until its result is in the output register.
// After a last request, min, max, sum, count and empty runs go straight to the result;
// average uses the 67-step divider and deviation the shift-add multiplier, divider
// and 24-step square root, all on one serial engine.
// Reset clears the running statistics, sets the mode to average and drops any pending result.
module rollup_statistics #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rstat_pkg::rstat_in_t         in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rstat_pkg::rstat_out_t        out_data_o,
  input  logic                         cfg_we_i,
  input  logic [rstat_pkg::MODE_W-1:0] cfg_wdata_i
);
  import rstat_pkg::*;

  // The controller sequences the end-of-run arithmetic; the datapath holds the
  // running statistics, the shared serial engine and the output register. A
  // finished result waits in that register while the next run is accumulated.
  rstat_cmd_t  cmd;
  rstat_stat_t stat;

  rstat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Samples beyond MAX_SAMPLES usable ones in a run are dropped in the datapath;
  // the last request still closes the run.
  rstat_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // A last request closes the request port on the next cycle.
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last |=> !in_ready_o)
    else $error("request port still open after a last request");

  // A new result only appears right after the request port was closed.
  a_result_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a finished run");

  // An empty run always reports a zero result.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_res |-> out_data_o.result == '0)
    else $error("empty run gave a non-zero result");
`endif

endmodule
